@@ rtl/core/fractional_period_tick_generator_unit_defines.svh @@
// Assertion macros shared by the checker of the tick generator.
// No dependencies; included by the checker file.
`ifndef FRACTIONAL_PERIOD_TICK_GENERATOR_UNIT_DEFINES_SVH
`define FRACTIONAL_PERIOD_TICK_GENERATOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPTG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tick generator check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FPTG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tick generator check failed");

`endif

@@ rtl/core/fptg_pkg.sv @@
// Shared types and constants of the fractional period tick generator.
// No dependencies; used by the top level, datapath, controller, checker and testbench.
`default_nettype none

package fptg_pkg;

    localparam int unsigned DEF_CLOCK_HZ          = 1000000;
    localparam int unsigned DEF_MAX_PRESCALE_CODE = 15;

    localparam int unsigned RATE_W     = 16;
    localparam int unsigned COMPARE_W  = 8;
    localparam int unsigned PRESCALE_W = 4;
    // Width of the period limit rate * (2^COMPARE_W - 1).
    localparam int unsigned LIM_W      = RATE_W + COMPARE_W;

    localparam logic MODE_RETUNE = 1'b0;
    localparam logic MODE_MATCH  = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [RATE_W-1:0] rate_hz;
        logic              callback_on;
    } req_t;

    typedef struct packed {
        logic [COMPARE_W-1:0]  compare_value;
        logic [PRESCALE_W-1:0] prescale_select;
        logic                  fire;
        logic                  error;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic match;
        logic reject;
        logic scan_init;
        logic scan_step;
        logic div_init;
        logic div_step;
        logic commit;
    } fptg_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_match;
        logic rate_bad;
        logic fits;
        logic at_max;
        logic div_last;
    } fptg_sts_t;

endpackage

`default_nettype wire

@@ rtl/core/fptg_stream_if.sv @@
// Valid/ready channel carrying one request or response payload.
// The payload type is set by the instantiating scope.
`default_nettype none

interface fptg_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/fractional_period_tick_generator_unit.sv @@
// A match request's response is valid in the cycle after it is accepted.
// A retune scans the prescaler codes upward from one, at most up to
// MAX_PRESCALE_CODE, then runs the restoring divider over DW = clog2(CLOCK_HZ+1)
// quotient bits and commits. Bad rates are rejected without a scan or a divide.
// Reset is asynchronous: the state clears, prescaler code one, outputs idle.
// Top level of the fractional period tick generator. Depends on fptg_pkg,
// fptg_stream_if, fptg_ctrl and fptg_datapath.
`default_nettype none

module fractional_period_tick_generator_unit
    import fptg_pkg::*;
#(
    parameter int unsigned CLOCK_HZ          = DEF_CLOCK_HZ,
    parameter int unsigned MAX_PRESCALE_CODE = DEF_MAX_PRESCALE_CODE
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    fptg_stream_if.sink   req,
    fptg_stream_if.source rsp
);

    fptg_cmd_t cmd;
    fptg_sts_t sts;
    rsp_t      rsp_data;
    logic      req_ready;
    logic      rsp_valid;

    fptg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    fptg_datapath #(
        .CLOCK_HZ          (CLOCK_HZ),
        .MAX_PRESCALE_CODE (MAX_PRESCALE_CODE)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req.data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp_data (rsp_data)
    );

    assign req.ready = req_ready;
    assign rsp.valid = rsp_valid;
    assign rsp.data  = rsp_data;

endmodule

`default_nettype wire

@@ rtl/core/fptg_datapath.sv @@
// Datapath of the tick generator: prescaler scan, restoring divider,
// cycle counter and the response register. Depends on fptg_pkg.
`default_nettype none

module fptg_datapath
    import fptg_pkg::*;
#(
    parameter int unsigned CLOCK_HZ          = DEF_CLOCK_HZ,
    parameter int unsigned MAX_PRESCALE_CODE = DEF_MAX_PRESCALE_CODE
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire req_t      req_data,
    input  wire fptg_cmd_t cmd,
    output fptg_sts_t      sts,
    output rsp_t           rsp_data
);

    localparam int unsigned DW = $clog2(CLOCK_HZ + 1);
    localparam int unsigned CW = $clog2(DW);
    localparam logic [RATE_W-1:0]     RATE_MAX     = RATE_W'(CLOCK_HZ / 256);
    localparam logic [DW-1:0]         CLOCK_VAL    = DW'(CLOCK_HZ);
    localparam logic [CW-1:0]         DIV_LAST_CNT = CW'(DW - 1);
    localparam logic [PRESCALE_W-1:0] CODE_MAX     = PRESCALE_W'(MAX_PRESCALE_CODE);
    localparam logic [PRESCALE_W-1:0] CODE_FIRST   = PRESCALE_W'(1);

    // Retune working registers.
    logic [RATE_W-1:0]     rate_reg;
    logic                  cb_reg;
    logic [DW-1:0]         div_reg;
    logic [RATE_W-1:0]     rem_reg;
    logic [CW-1:0]         cnt_reg;
    logic [PRESCALE_W-1:0] code_reg;

    // Architectural state.
    logic [RATE_W-1:0]     cycle_count_reg,  cycle_count_next;
    logic [RATE_W-1:0]     cycle_length_reg;
    logic [COMPARE_W-1:0]  low_period_reg;
    logic [RATE_W-1:0]     switch_point_reg;
    logic                  active_reg;
    logic [COMPARE_W-1:0]  compare_reg,      compare_next;
    logic [PRESCALE_W-1:0] prescale_reg;

    rsp_t                  rsp_reg;

    logic [LIM_W-1:0]      lim;
    logic [RATE_W:0]       trial;
    logic [RATE_W:0]       diff;
    logic                  ge;
    logic [RATE_W-1:0]     count_inc;
    logic [COMPARE_W-1:0]  compare_hit;

    // The quotient stays at or below 254 exactly when the dividend is
    // below 255 times the rate.
    assign lim   = (LIM_W'(rate_reg) << COMPARE_W) - LIM_W'(rate_reg);
    assign trial = {rem_reg, div_reg[DW-1]};
    assign ge    = trial >= {1'b0, rate_reg};
    assign diff  = trial - {1'b0, rate_reg};

    always_comb
    begin
        sts.is_match = req_data.mode == MODE_MATCH;
        sts.rate_bad = (req_data.rate_hz == '0) || (req_data.rate_hz > RATE_MAX);
        sts.fits     = LIM_W'(div_reg) < lim;
        sts.at_max   = code_reg >= CODE_MAX;
        sts.div_last = cnt_reg == '0;
    end

    // Match event: switch to the long period at the switch point and back
    // to the short period when the counter wraps.
    always_comb
    begin
        compare_hit = (cycle_count_reg == switch_point_reg)
                    ? low_period_reg + COMPARE_W'(1) : compare_reg;
        count_inc   = cycle_count_reg + RATE_W'(1);
        if (count_inc >= cycle_length_reg)
        begin
            compare_next     = low_period_reg;
            cycle_count_next = '0;
        end
        else
        begin
            compare_next     = compare_hit;
            cycle_count_next = count_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_init)
        begin
            rate_reg <= req_data.rate_hz;
            cb_reg   <= req_data.callback_on;
            div_reg  <= CLOCK_VAL;
            code_reg <= CODE_FIRST;
        end
        else if (cmd.scan_step)
        begin
            div_reg  <= div_reg >> 1;
            code_reg <= code_reg + PRESCALE_W'(1);
        end
        else if (cmd.div_step)
        begin
            div_reg  <= {div_reg[DW-2:0], ge};
        end

        if (cmd.div_init)
        begin
            rem_reg <= '0;
            cnt_reg <= DIV_LAST_CNT;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= ge ? diff[RATE_W-1:0] : trial[RATE_W-1:0];
            cnt_reg <= cnt_reg - CW'(1);
        end

        if (cmd.commit)
        begin
            rsp_reg.compare_value   <= div_reg[COMPARE_W-1:0];
            rsp_reg.prescale_select <= code_reg;
            rsp_reg.fire            <= 1'b0;
            rsp_reg.error           <= 1'b0;
        end
        else if (cmd.reject)
        begin
            rsp_reg.compare_value   <= compare_reg;
            rsp_reg.prescale_select <= prescale_reg;
            rsp_reg.fire            <= 1'b0;
            rsp_reg.error           <= 1'b1;
        end
        else if (cmd.match)
        begin
            rsp_reg.compare_value   <= active_reg ? compare_next : compare_reg;
            rsp_reg.prescale_select <= prescale_reg;
            rsp_reg.fire            <= active_reg;
            rsp_reg.error           <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycle_count_reg  <= '0;
            cycle_length_reg <= '0;
            low_period_reg   <= '0;
            switch_point_reg <= '0;
            active_reg       <= 1'b0;
            compare_reg      <= '0;
            prescale_reg     <= CODE_FIRST;
        end
        else if (cmd.commit)
        begin
            cycle_count_reg  <= '0;
            cycle_length_reg <= rate_reg;
            low_period_reg   <= div_reg[COMPARE_W-1:0];
            switch_point_reg <= rate_reg - rem_reg;
            active_reg       <= cb_reg;
            compare_reg      <= div_reg[COMPARE_W-1:0];
            prescale_reg     <= code_reg;
        end
        else if (cmd.match && active_reg)
        begin
            cycle_count_reg  <= cycle_count_next;
            compare_reg      <= compare_next;
        end
    end

    assign rsp_data = rsp_reg;

endmodule

`default_nettype wire

@@ rtl/core/fptg_ctrl.sv @@
// Controller of the tick generator: sequences the prescaler scan and the
// divider and owns the channel handshakes. Depends on fptg_pkg.
`default_nettype none

module fptg_ctrl
    import fptg_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      req_valid,
    output logic           req_ready,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    input  wire fptg_sts_t sts,
    output fptg_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DIVIDE,
        ST_COMMIT
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   accept;

    // A request is taken only when the response register is free or
    // drains at the same edge, so every result can be loaded at once.
    assign req_ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp_ready);
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (sts.is_match)
                    begin
                        cmd.match = 1'b1;
                    end
                    else if (sts.rate_bad)
                    begin
                        cmd.reject = 1'b1;
                    end
                    else
                    begin
                        cmd.scan_init = 1'b1;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (sts.fits)
                begin
                    cmd.div_init = 1'b1;
                    state_next   = ST_DIVIDE;
                end
                else if (sts.at_max)
                begin
                    cmd.reject = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            ST_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.match || cmd.reject || cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/fptg_checker.sv @@
// Port-level checks of the tick generator, bound to the top level.
// Depends on fptg_pkg and the assertion macro header.
`default_nettype none
`include "fractional_period_tick_generator_unit_defines.svh"

module fptg_checker
    import fptg_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  req_valid,
    input wire logic                  req_ready,
    input wire logic                  req_mode,
    input wire logic                  rsp_valid,
    input wire logic                  rsp_ready,
    input wire logic [PRESCALE_W-1:0] rsp_prescale,
    input wire logic                  rsp_fire,
    input wire logic                  rsp_error
);

    `FPTG_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid)
    `FPTG_ASSERT_IMPL(a_fire_no_error, clk, rst_n, rsp_valid && rsp_fire, !rsp_error)
    `FPTG_ASSERT_IMPL(a_prescale_nonzero, clk, rst_n, rsp_valid, rsp_prescale != '0)
    `FPTG_ASSERT_NEXT(a_match_one_cycle, clk, rst_n, req_valid && req_ready && req_mode == MODE_MATCH, rsp_valid)

endmodule

bind fractional_period_tick_generator_unit fptg_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .req_mode     (req.data.mode),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_prescale (rsp.data.prescale_select),
    .rsp_fire     (rsp.data.fire),
    .rsp_error    (rsp.data.error)
);

`default_nettype wire

@@ sim/tb_fractional_period_tick_generator_unit.sv @@
// Self-checking testbench for the fractional period tick generator unit.
// Depends on fptg_pkg, fptg_stream_if and the RTL top level with its controller and datapath.
// A scoreboard class predicts every response from the requests the block accepts.
module tb_fractional_period_tick_generator_unit;
    import fptg_pkg::*;

    localparam int unsigned CLK_HZ         = DEF_CLOCK_HZ;
    localparam int unsigned MAX_CODE       = DEF_MAX_PRESCALE_CODE;
    localparam int unsigned LOW_LIMIT      = 254;
    localparam int unsigned MAX_RATE       = CLK_HZ / 256;
    localparam int unsigned RANDOM_ITEMS   = 750;
    localparam int unsigned CALM_ITEMS     = 120;
    localparam int unsigned DRAIN_CYCLES   = 60;
    localparam int unsigned WATCHDOG_LIMIT = 3000;
    localparam int unsigned MAX_PRINTS     = 30;

    class tick_scoreboard;
        logic [15:0] cycle_count;
        logic [15:0] cycle_length;
        logic [15:0] switch_point;
        logic [7:0]  low_period;
        logic [7:0]  cur_compare;
        logic [3:0]  cur_prescale;
        logic        active;
        rsp_t        awaited[$];
        int unsigned mismatches;
        int unsigned retunes;
        int unsigned rejects;
        int unsigned match_count;
        int unsigned fires;

        function new();
            cycle_count  = '0;
            cycle_length = '0;
            switch_point = '0;
            low_period   = '0;
            cur_compare  = '0;
            cur_prescale = 4'd1;
            active       = 1'b0;
            mismatches   = 0;
            retunes      = 0;
            rejects      = 0;
            match_count  = 0;
            fires        = 0;
        endfunction

        // Returns 0 when the rate is rejected; the state is then left alone.
        function bit apply_retune(logic [15:0] rate, logic cb);
            longint unsigned pre;
            longint unsigned code;
            longint unsigned q;
            if (rate == 0 || rate > MAX_RATE)
                return 1'b0;
            pre  = 1;
            code = 1;
            q    = longint'(CLK_HZ) / longint'(rate);
            while (q > LOW_LIMIT && code < MAX_CODE)
            begin
                pre  = pre << 1;
                code = code + 1;
                q    = longint'(CLK_HZ) / (pre * longint'(rate));
            end
            if (q > LOW_LIMIT)
                return 1'b0;
            low_period   = 8'(q);
            cycle_length = rate;
            switch_point = 16'(longint'(rate) - (longint'(CLK_HZ) / pre) % longint'(rate));
            cycle_count  = '0;
            active       = cb;
            cur_compare  = 8'(q);
            cur_prescale = 4'(code);
            return 1'b1;
        endfunction

        function void note_request(req_t r);
            rsp_t want;
            want.fire  = 1'b0;
            want.error = 1'b0;
            if (r.mode == MODE_RETUNE)
            begin
                retunes++;
                if (!apply_retune(r.rate_hz, r.callback_on))
                begin
                    want.error = 1'b1;
                    rejects++;
                end
            end
            else
            begin
                match_count++;
                if (active)
                begin
                    if (cycle_count == switch_point)
                        cur_compare = low_period + 8'd1;
                    cycle_count = cycle_count + 16'd1;
                    if (cycle_count >= cycle_length)
                    begin
                        cur_compare = low_period;
                        cycle_count = '0;
                    end
                    want.fire = 1'b1;
                    fires++;
                end
            end
            want.compare_value   = cur_compare;
            want.prescale_select = cur_prescale;
            awaited.push_back(want);
        endfunction

        task report(string what, int unsigned got, int unsigned want);
            mismatches++;
            if (mismatches <= MAX_PRINTS)
                $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
        endtask

        task check_result(rsp_t got);
            rsp_t want;
            if (awaited.size() == 0)
            begin
                report("unexpected response", 1, 0);
                return;
            end
            want = awaited.pop_front();
            if (got.compare_value !== want.compare_value)
                report("compare_value", got.compare_value, want.compare_value);
            if (got.prescale_select !== want.prescale_select)
                report("prescale_select", got.prescale_select, want.prescale_select);
            if (got.fire !== want.fire)
                report("fire", got.fire, want.fire);
            if (got.error !== want.error)
                report("error", got.error, want.error);
        endtask
    endclass

    logic clk;
    logic rst_n;
    bit   idle_on = 1'b1;
    int unsigned quiet_cycles = 0;
    tick_scoreboard sb = new();

    fptg_stream_if #(.T(req_t)) req_if ();
    fptg_stream_if #(.T(rsp_t)) rsp_if ();

    fractional_period_tick_generator_unit #(
        .CLOCK_HZ          (CLK_HZ),
        .MAX_PRESCALE_CODE (MAX_CODE)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic req_t make_req(logic mode, logic [15:0] rate, logic cb);
        req_t r;
        r.mode        = mode;
        r.rate_hz     = rate;
        r.callback_on = cb;
        return r;
    endfunction

    // Mostly match events over short rate cycles, so the period switch and the
    // wrap are reached often; now and then a retune, some of them bad.
    function automatic req_t random_request();
        req_t r;
        int unsigned pick;
        r.mode        = MODE_MATCH;
        r.rate_hz     = 16'($urandom);
        r.callback_on = 1'($urandom);
        if ($urandom_range(0, 99) < 9)
        begin
            r.mode        = MODE_RETUNE;
            r.callback_on = ($urandom_range(0, 4) != 0);
            pick          = $urandom_range(0, 99);
            if (pick < 55)
                r.rate_hz = 16'($urandom_range(1, 12));
            else if (pick < 68)
                r.rate_hz = 16'($urandom_range(13, 60));
            else if (pick < 78)
                r.rate_hz = 16'($urandom_range(1, MAX_RATE));
            else if (pick < 86)
                r.rate_hz = 16'($urandom_range(MAX_RATE - 4, MAX_RATE + 4));
            else if (pick < 96)
                r.rate_hz = 16'($urandom);
            else
                r.rate_hz = '0;
        end
        return r;
    endfunction

    // Leaves valid high on return so that the next request can follow back to back.
    task send_request(req_t r);
        int unsigned gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 17);
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_request(r);
    endtask

    initial
    begin
        int unsigned stall;
        stall = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.data);
            if (stall != 0)
                stall--;
            else if (idle_on && $urandom_range(0, 4) == 0)
                stall = $urandom_range(1, 17);
            rsp_if.ready <= (stall == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] no request or response moved for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_fractional_period_tick_generator_unit: errors");
            $finish;
        end
    end

    initial
    begin
        rst_n        <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Match before any retune, then the rejected rates.
        send_request(make_req(MODE_MATCH, 16'd0, 1'b1));
        send_request(make_req(MODE_RETUNE, 16'd0, 1'b1));
        send_request(make_req(MODE_RETUNE, 16'(MAX_RATE + 1), 1'b1));
        send_request(make_req(MODE_RETUNE, 16'hffff, 1'b0));
        // Highest legal rate, then the lowest one with the deepest prescaler.
        send_request(make_req(MODE_RETUNE, 16'(MAX_RATE), 1'b1));
        send_request(make_req(MODE_MATCH, 16'hffff, 1'b0));
        send_request(make_req(MODE_RETUNE, 16'd1, 1'b1));
        send_request(make_req(MODE_MATCH, 16'd0, 1'b0));
        send_request(make_req(MODE_MATCH, 16'd0, 1'b1));
        // A rate of 4 divides the prescaled clock evenly, so the period stays low.
        send_request(make_req(MODE_RETUNE, 16'd4, 1'b1));
        repeat (5) send_request(make_req(MODE_MATCH, 16'd0, 1'b0));
        // A rate of 3 leaves a remainder and switches to the long period mid-cycle.
        send_request(make_req(MODE_RETUNE, 16'd3, 1'b1));
        repeat (4) send_request(make_req(MODE_MATCH, 16'd0, 1'b0));
        // Retune with the action disabled; matches must not fire.
        send_request(make_req(MODE_RETUNE, 16'd5, 1'b0));
        send_request(make_req(MODE_MATCH, 16'd0, 1'b0));
        send_request(make_req(MODE_MATCH, 16'hffff, 1'b1));

        for (int unsigned i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS - CALM_ITEMS)
                idle_on = 1'b0;
            send_request(random_request());
        end
        req_if.valid <= 1'b0;

        while (sb.awaited.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d retunes (%0d rejected) and %0d match events, %0d firing.",
                 sb.retunes, sb.rejects, sb.match_count, sb.fires);
        $display("Field mismatches counted: %0d.", sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb_fractional_period_tick_generator_unit: clean");
        else
            $display("tb_fractional_period_tick_generator_unit: errors");
        $finish;
    end

endmodule
